// ===== hdl/splitmix64_bounded_random_top_defines.svh =====
// assertion macros used by the top-level rtl file
`ifndef SPLITMIX64_BOUNDED_RANDOM_TOP_DEFINES_SVH
`define SPLITMIX64_BOUNDED_RANDOM_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define SM64_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define SM64_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sm64_pkg.sv =====
`timescale 1ns / 1ps

package sm64_pkg;

  localparam int WORD_W  = 64;
  localparam int REJ_W   = 8;
  localparam int STEP_W  = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;
  localparam logic [WORD_W-1:0] SEED_RESET = 64'd20260715;

  localparam int SHIFT_A = 30;
  localparam int SHIFT_B = 27;
  localparam int SHIFT_C = 31;

  localparam logic [REJ_W-1:0] REJ_MAX = '1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [REJ_W-1:0]  rej_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THRESH,
    ST_DRAW,
    ST_MUL_A,
    ST_MUL_B,
    ST_REDUCE,
    ST_HOLD
  } state_t;

endpackage

// ===== hdl/sm64_mul.sv =====
`timescale 1ns / 1ps

// bit-serial shift-add multiplier, low word of the product
module sm64_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sm64_pkg::word_t mcand,
  input  sm64_pkg::word_t mplier,
  output logic          busy,
  output logic          done,
  output sm64_pkg::word_t product
);
  import sm64_pkg::*;

  word_t             a_r, a_nxt;
  word_t             b_r, b_nxt;
  word_t             acc_r, acc_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = mcand;
      b_nxt    = mplier;
      acc_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt    = a_r << 1;
      b_nxt    = b_r >> 1;
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== hdl/sm64_mod.sv =====
`timescale 1ns / 1ps

// restoring remainder, one numerator bit per cycle
module sm64_mod (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sm64_pkg::word_t num,
  input  sm64_pkg::word_t den,
  output logic          done,
  output sm64_pkg::word_t rem
);
  import sm64_pkg::*;

  word_t             n_r, n_nxt;
  word_t             d_r, d_nxt;
  word_t             rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  always_comb begin
    trial    = {rem_r, n_r[WORD_W-1]};
    diff     = trial - {1'b0, d_r};
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = num;
      d_nxt    = den;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below den, so the trial fits in one extra bit
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = diff[WORD_W-1:0];
      end else begin
        rem_nxt = trial[WORD_W-1:0];
      end
      n_nxt    = n_r << 1;
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hdl/splitmix64_bounded_random_top.sv =====
// channel   | handshake           | payload
// ----------+---------------------+-------------------------------
// request   | in_valid / in_ready | in_restart, in_bound
// result    | out_valid/out_ready | out_value, out_rejections
// config    | cfg_we              | cfg_wdata (seed)
//
// one request at a time; multiplies and remainders run as bit-serial passes
// bound zero: the result register loads after the two mixing multiplies
// nonzero bound: threshold remainder, two multiplies per draw, final remainder
// in_ready returns together with out_valid, when the output register loads; a result still
// waiting in the output register holds the block in hold, in_ready stays low
// rst_n is synchronous, active low; seed and generator state reset to 20260715
`timescale 1ns / 1ps
`include "splitmix64_bounded_random_top_defines.svh"

module splitmix64_bounded_random_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_restart,
  input  sm64_pkg::word_t in_bound,
  output logic            out_valid,
  input  logic            out_ready,
  output sm64_pkg::word_t out_value,
  output sm64_pkg::rej_t  out_rejections,
  input  logic            cfg_we,
  input  sm64_pkg::word_t cfg_wdata
);
  import sm64_pkg::*;

  // control and datapath registers
  state_t state_r, state_nxt;
  word_t  seed_r;
  word_t  gen_r, gen_nxt;        // generator state
  word_t  bound_r, bound_nxt;
  word_t  thr_r, thr_nxt;        // rejection threshold
  rej_t   cnt_r, cnt_nxt;        // saturating rejection count
  word_t  res_r, res_nxt;        // finished value waiting for the output register
  logic   out_valid_r, out_valid_nxt;
  word_t  out_value_r, out_value_nxt;
  rej_t   out_rej_r, out_rej_nxt;

  // serial units, the multiplier is shared by both mixing rounds
  logic   mul_start, mul_busy, mul_done;
  word_t  mul_mcand, mul_mplier, mul_prod;
  logic   mod_start, mod_done;
  word_t  mod_num, mod_den, mod_rem;

  word_t  draw_sum, mix_a_in, mix_b_in, draw_z;
  logic   in_xfer;

  sm64_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_prod)
  );

  sm64_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (mod_num),
    .den   (mod_den),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // mixing steps around the serial multiplies
  assign draw_sum = gen_r + GOLDEN_INC;
  assign mix_a_in = draw_sum ^ (draw_sum >> SHIFT_A);
  assign mix_b_in = mul_prod ^ (mul_prod >> SHIFT_B);
  assign draw_z   = mul_prod ^ (mul_prod >> SHIFT_C);

  // first multiply starts from the draw state, second from the first product
  assign mul_mcand  = (state_r == ST_DRAW) ? mix_a_in : mix_b_in;
  assign mul_mplier = (state_r == ST_DRAW) ? MIX_MUL_A : MIX_MUL_B;

  // threshold pass works on 2^64 - bound, final pass on the accepted draw
  assign mod_num = (state_r == ST_IDLE) ? (word_t'(0) - in_bound) : draw_z;
  assign mod_den = (state_r == ST_IDLE) ? in_bound : bound_r;

  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    bound_nxt     = bound_r;
    thr_nxt       = thr_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_rej_nxt   = out_rej_r;
    mul_start     = 1'b0;
    mod_start     = 1'b0;

    // result transfer frees the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          bound_nxt = in_bound;
          cnt_nxt   = '0;
          if (in_restart) begin
            gen_nxt = seed_r;
          end
          if (in_bound != '0) begin
            mod_start = 1'b1;
            state_nxt = ST_THRESH;
          end else begin
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_THRESH: begin
        if (mod_done) begin
          thr_nxt   = mod_rem;
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        // advance the generator and start the first mixing multiply
        gen_nxt   = draw_sum;
        mul_start = 1'b1;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (mul_done) begin
          priority if (bound_r == '0) begin
            // raw draw, no reduction
            res_nxt   = draw_z;
            state_nxt = ST_HOLD;
          end else if (draw_z < thr_r) begin
            // rejected, draw again
            if (cnt_r != REJ_MAX) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            state_nxt = ST_DRAW;
          end else begin
            mod_start = 1'b1;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mod_done) begin
          res_nxt   = mod_rem;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for a free output register
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_rej_nxt   = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= SEED_RESET;
      gen_r       <= SEED_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
    bound_r     <= bound_nxt;
    thr_r       <= thr_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_rejections = out_rej_r;

  // the shared multiplier is only started when free
  `SM64_ASSERT_NOW(a_mul_free, mul_start, !mul_busy, "multiplier started while busy")
  // restart loads the seed into the generator
  `SM64_ASSERT_NEXT(a_restart_seed, in_xfer && in_restart, gen_r == $past(seed_r), "no seed")
  // raw draws never count rejections
  `SM64_ASSERT_NOW(a_raw_no_rej, (state_r == ST_HOLD) && (bound_r == '0), cnt_r == '0, "rej")
  // reduced value lies below the bound
  `SM64_ASSERT_NOW(a_reduce_range, (state_r == ST_REDUCE) && mod_done, mod_rem < bound_r, "range")

endmodule
